/* design/ntes_pkg.sv */
// shared types, constants and codes for the next event timer scheduler
`timescale 1ns / 1ps
`default_nettype none
package ntes_pkg;

   // slot bank geometry
   localparam int SLOTS       = 8;
   localparam int MAX_REPORTS = 8;
   localparam int SLOT_IDX_W  = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(MAX_REPORTS);

   // field widths
   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 3;
   localparam int DUR_W      = 32;
   localparam int TIME_W     = 64;
   localparam int KIND_W     = 2;

   // least remaining time before any waiting slot is seen
   localparam logic [DUR_W-1:0] NO_WAIT_MIN = 32'hFFFF_FFFF;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ARM     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SET     = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic exec;         // perform arm or set on the accepted word
      logic scan_start;   // clear scan index, minimum, mask and report count
      logic min_step;     // fold one slot into the running minimum
      logic sub_step;     // subtract the minimum from one slot
      logic out_ack;      // load an acknowledge word
      logic out_none;     // load a nothing-waiting word
      logic out_report;   // load the next expiry word and retire that slot
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_advance;   // offered word asks for an advance
      logic idx_last;     // scan index sits on the highest slot
      logic any_found;    // some waiting slot seen, including the current one
      logic out_free;     // output register can take a word this cycle
      logic report_last;  // the expiry word being loaded ends the item
   } status_type;

endpackage
`default_nettype wire

/* design/ntes_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ntes_req_if;
   logic                          valid;
   logic                          ready;
   logic [ntes_pkg::MODE_W-1:0]   mode;
   logic [ntes_pkg::SLOT_W-1:0]   slot;
   logic [ntes_pkg::DUR_W-1:0]    duration;
   logic [ntes_pkg::TIME_W-1:0]   time_value;

   modport source (output valid, output mode, output slot, output duration,
                   output time_value, input ready);
   modport sink   (input valid, input mode, input slot, input duration,
                   input time_value, output ready);
endinterface

interface ntes_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ntes_pkg::KIND_W-1:0]   kind;
   logic [ntes_pkg::SLOT_W-1:0]   fired_slot;
   logic [ntes_pkg::TIME_W-1:0]   time_now;
   logic                          last;

   modport source (output valid, output kind, output fired_slot, output time_now,
                   output last, input ready);
   modport sink   (input valid, input kind, input fired_slot, input time_now,
                   input last, output ready);
endinterface
`default_nettype wire

/* design/ntes_dpath.sv */
// datapath: slot bank, timestamp, minimum scan, expiry mask and output register
`timescale 1ns / 1ps
`default_nettype none
module ntes_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ntes_pkg::cmd_type               cmd,
   output      ntes_pkg::status_type            status,
   input  wire logic [ntes_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [ntes_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [ntes_pkg::DUR_W-1:0]      req_duration,
   input  wire logic [ntes_pkg::TIME_W-1:0]     req_time_value,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_valid,
   output      logic [ntes_pkg::KIND_W-1:0]     rsp_kind,
   output      logic [ntes_pkg::SLOT_W-1:0]     rsp_fired_slot,
   output      logic [ntes_pkg::TIME_W-1:0]     rsp_time_now,
   output      logic                            rsp_last
);

   // slot bank and timestamp
   logic [ntes_pkg::DUR_W-1:0]      remaining_ff [ntes_pkg::SLOTS];
   logic [ntes_pkg::SLOTS-1:0]      waiting_ff;
   logic [ntes_pkg::TIME_W-1:0]     timestamp_ff;

   // scan state
   logic [ntes_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic [ntes_pkg::DUR_W-1:0]      least_ff;
   logic                            any_ff;
   logic [ntes_pkg::SLOTS-1:0]      mask_ff;
   logic [ntes_pkg::CNT_W-1:0]      cnt_ff;

   // output register
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ntes_pkg::KIND_W-1:0]     rsp_kind_ff;
   logic [ntes_pkg::SLOT_W-1:0]     rsp_fired_slot_ff;
   logic [ntes_pkg::TIME_W-1:0]     rsp_time_now_ff;
   logic                            rsp_last_ff;

   logic [ntes_pkg::DUR_W-1:0]      cur;
   logic                            cur_waiting;
   logic [ntes_pkg::DUR_W-1:0]      diff;
   logic                            idx_last;
   logic [ntes_pkg::SLOT_IDX_W-1:0] sel;
   logic [ntes_pkg::SLOTS-1:0]      mask_less;
   logic                            slot_ok;

   // current slot of the scan
   assign cur         = remaining_ff[idx_ff];
   assign cur_waiting = waiting_ff[idx_ff];
   assign diff        = cur - least_ff;
   assign idx_last    = (idx_ff == ntes_pkg::SLOT_IDX_W'(ntes_pkg::SLOTS - 1));
   assign slot_ok     = (int'(req_slot) < ntes_pkg::SLOTS);

   // lowest pending expiry
   always_comb begin
      sel = '0;
      for (int i = ntes_pkg::SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = ntes_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   assign mask_less = mask_ff & (mask_ff - ntes_pkg::SLOTS'(1));

   // status back to the controller
   always_comb begin
      status.is_advance  = (req_mode == ntes_pkg::MODE_ADVANCE);
      status.idx_last    = idx_last;
      status.any_found   = any_ff | cur_waiting;
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.report_last = (mask_less == '0) ||
                           (cnt_ff == ntes_pkg::CNT_W'(ntes_pkg::MAX_REPORTS - 1));
   end

   // slot remaining times: arm writes, subtract pass updates
   always_ff @(posedge clock) begin
      if (cmd.exec && req_mode == ntes_pkg::MODE_ARM && slot_ok) begin
         remaining_ff[req_slot[ntes_pkg::SLOT_IDX_W-1:0]] <= req_duration;
      end else if (cmd.sub_step && cur_waiting) begin
         remaining_ff[idx_ff] <= diff;
      end
   end

   // waiting flags and timestamp
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= '0;
         timestamp_ff <= '0;
      end else begin
         if (cmd.exec && req_mode == ntes_pkg::MODE_ARM && slot_ok) begin
            waiting_ff[req_slot[ntes_pkg::SLOT_IDX_W-1:0]] <= 1'b1;
         end else if (cmd.out_report) begin
            waiting_ff[sel] <= 1'b0;
         end
         if (cmd.exec && req_mode == ntes_pkg::MODE_SET) begin
            timestamp_ff <= req_time_value;
         end else if (cmd.sub_step && idx_last) begin
            timestamp_ff <= timestamp_ff + {{(ntes_pkg::TIME_W - ntes_pkg::DUR_W){1'b0}},
                                            least_ff};
         end
      end
   end

   // scan index, running minimum, expiry mask and report count
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         least_ff <= ntes_pkg::NO_WAIT_MIN;
         any_ff   <= 1'b0;
         mask_ff  <= '0;
         cnt_ff   <= '0;
      end else if (cmd.scan_start) begin
         idx_ff   <= '0;
         least_ff <= ntes_pkg::NO_WAIT_MIN;
         any_ff   <= 1'b0;
         mask_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.min_step || cmd.sub_step) begin
            idx_ff <= idx_last ? '0 : idx_ff + ntes_pkg::SLOT_IDX_W'(1);
         end
         if (cmd.min_step && cur_waiting) begin
            any_ff <= 1'b1;
            if (cur < least_ff) begin
               least_ff <= cur;
            end
         end
         if (cmd.sub_step && cur_waiting && diff == '0) begin
            mask_ff[idx_ff] <= 1'b1;
         end
         if (cmd.out_report) begin
            mask_ff[sel] <= 1'b0;
            cnt_ff       <= cnt_ff + ntes_pkg::CNT_W'(1);
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ack || cmd.out_none || cmd.out_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.out_report) begin
         rsp_kind_ff       <= ntes_pkg::KIND_EXPIRED;
         rsp_fired_slot_ff <= sel;
         rsp_time_now_ff   <= timestamp_ff;
         rsp_last_ff       <= status.report_last;
      end else if (cmd.out_ack || cmd.out_none) begin
         rsp_kind_ff       <= cmd.out_none ? ntes_pkg::KIND_NONE : ntes_pkg::KIND_ACK;
         rsp_fired_slot_ff <= '0;
         rsp_time_now_ff   <= timestamp_ff;
         rsp_last_ff       <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_time_now   = rsp_time_now_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire

/* design/ntes_ctrl.sv */
// controller: sequences accept, minimum scan, subtract pass and reporting
`timescale 1ns / 1ps
`default_nettype none
module ntes_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire ntes_pkg::status_type  status,
   output      ntes_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ACK    = 3'd1;
   localparam logic [2:0] ST_MIN    = 3'd2;
   localparam logic [2:0] ST_SUB    = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;
   localparam logic [2:0] ST_NONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               if (status.is_advance) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_MIN;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.out_ack = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            if (status.idx_last) begin
               state_in = status.any_found ? ST_SUB : ST_NONE;
            end
         end
         ST_SUB: begin
            cmd.sub_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (status.out_free) begin
               cmd.out_report = 1'b1;
               if (status.report_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NONE: begin
            if (status.out_free) begin
               cmd.out_none = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* design/next_event_timer_scheduler_unit.sv */
// top level of the next event timer scheduler
//
//   channel   dir   handshake          words
//   req_ch    in    valid / ready      mode, slot, duration, time_value
//   rsp_ch    out   valid / ready      kind, fired_slot, time_now, last
//
// arm, set and unused modes are accepted, then answered with the acknowledge word.
// advance runs the minimum scan over all SLOTS slots, then the subtract pass over
// all slots, then one expiry word per expired slot; with nothing waiting the scan
// is followed by a nothing-waiting word. both scans use the single bank read port.
// reset is synchronous: waiting flags, timestamp and control clear.
// a stalled response holds the sequencer; a new word is taken only between items.
`timescale 1ns / 1ps
`default_nettype none
module next_event_timer_scheduler_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   ntes_req_if.sink   req_ch,
   ntes_rsp_if.source rsp_ch
);

   ntes_pkg::cmd_type    cmd;
   ntes_pkg::status_type status;

   // sequencer
   ntes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot bank and output register
   ntes_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_ch.mode),
      .req_slot       (req_ch.slot),
      .req_duration   (req_ch.duration),
      .req_time_value (req_ch.time_value),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_kind       (rsp_ch.kind),
      .rsp_fired_slot (rsp_ch.fired_slot),
      .rsp_time_now   (rsp_ch.time_now),
      .rsp_last       (rsp_ch.last)
   );

endmodule
`default_nettype wire

/* design/ntes_chk.sv */
// port-level checker for the next event timer scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ntes_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [ntes_pkg::MODE_W-1:0]   req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ntes_pkg::KIND_W-1:0]   rsp_kind,
   input wire logic [ntes_pkg::SLOT_W-1:0]   rsp_fired_slot,
   input wire logic [ntes_pkg::TIME_W-1:0]   rsp_time_now,
   input wire logic                          rsp_last
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_fired_slot) && $stable(rsp_time_now) && $stable(rsp_last))
      else $error("response changed while stalled");

   // an accepted word takes ready away from the next one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken before previous item finished");

   // acknowledge and idle words are single and carry no slot
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ntes_pkg::KIND_EXPIRED |-> rsp_last && rsp_fired_slot == '0)
      else $error("acknowledge or idle word malformed");

   // non-advance words taken with no word held are answered by an acknowledge
   a_ack: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != ntes_pkg::MODE_ADVANCE && !rsp_valid
      |=> ##1 rsp_valid && rsp_kind == ntes_pkg::KIND_ACK)
      else $error("missing acknowledge");

endmodule

bind next_event_timer_scheduler_unit ntes_chk u_ntes_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_mode       (req_ch.mode),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_fired_slot (rsp_ch.fired_slot),
   .rsp_time_now   (rsp_ch.time_now),
   .rsp_last       (rsp_ch.last)
);
`default_nettype wire
